[hdl/sls_pkg.sv]
// Shared types and codes for the searchable LIFO stack.
// Used by sls_ctrl, sls_dp, searchable_lifo_stack and sls_chk; no dependencies.
package sls_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 3;
  localparam int KIND_W = 3;
  localparam int STAT_W = 2;

  typedef enum logic [KIND_W-1:0] {
    REQ_PUSH   = 3'd0,
    REQ_POP    = 3'd1,
    REQ_LIST   = 3'd2,
    REQ_SEARCH = 3'd3,
    REQ_UPDATE = 3'd4
  } req_kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_MISS  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_POP,
    S_WALK
  } state_e;

  typedef struct packed {
    logic [KIND_W-1:0]        req_type;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] new_value;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] data;
    logic [IDX_W-1:0]         index;
    logic                     last;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic    take;     // latch the incoming beat
    logic    rd_top;   // ptr <= top, read it
    logic    rd_next;  // ptr <= ptr - 1, read it
    logic    push;
    logic    pop;
    logic    upd;
    logic    emit;     // load the output register
    status_e status;
    logic    data_rd;  // data from the read port, else zero
    logic    idx_ptr;  // index from ptr, else zero
    logic    last_ptr; // last when ptr is zero, else always last
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              full;
    logic              empty;
    logic              match;
    logic              ptr_zero;
    logic              out_free;
  } stat_t;

endpackage

[hdl/searchable_lifo_stack.sv]
// Top level of the searchable LIFO stack: joins sls_ctrl and sls_dp.
// Depends on sls_pkg, sls_ctrl and sls_dp.
//
// A LIFO of DEPTH signed 32-bit words with push, pop, list, search and
// update requests. One request is handled at a time; req_stall is low only
// while the block is idle, and a finished result may still sit in the output
// register while the next request is taken. List, search and update walk
// the entry memory through its registered read port one entry per cycle
// from the top down; a list walk waits while rsp_stall holds back a beat.
// Search and update stop at the first match; not found comes only after
// the whole walk. Request kinds 5..7 are dropped with no result. Any step
// that emits a result waits while rsp_stall holds back the previous beat.
// The index field is the entry index modulo 8.
module searchable_lifo_stack #(
  parameter int DEPTH = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  sls_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output sls_pkg::rsp_t rsp
);

  sls_pkg::cmd_t  cmd;
  sls_pkg::stat_t stat;
  logic           idle;

  assign req_stall = !idle;

  sls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .stat      (stat),
    .idle      (idle),
    .cmd       (cmd)
  );

  sls_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

[hdl/sls_ctrl.sv]
// Sequencer for the searchable LIFO stack.
// Depends on sls_pkg; drives sls_dp through cmd_t and watches stat_t.
module sls_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  sls_pkg::stat_t stat,
  output logic           idle,
  output sls_pkg::cmd_t  cmd
);

  sls_pkg::state_e state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sls_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sls_pkg::S_IDLE: begin
        if (req_valid) state_next = sls_pkg::S_DECODE;
      end
      sls_pkg::S_DECODE: begin
        case (stat.kind)
          sls_pkg::REQ_PUSH: begin
            if (stat.out_free) state_next = sls_pkg::S_IDLE;
          end
          sls_pkg::REQ_POP: begin
            if (!stat.empty) state_next = sls_pkg::S_POP;
            else if (stat.out_free) state_next = sls_pkg::S_IDLE;
          end
          sls_pkg::REQ_LIST, sls_pkg::REQ_SEARCH, sls_pkg::REQ_UPDATE: begin
            if (!stat.empty) state_next = sls_pkg::S_WALK;
            else if (stat.out_free) state_next = sls_pkg::S_IDLE;
          end
          default: state_next = sls_pkg::S_IDLE;
        endcase
      end
      sls_pkg::S_POP: begin
        if (stat.out_free) state_next = sls_pkg::S_IDLE;
      end
      sls_pkg::S_WALK: begin
        if (stat.kind == sls_pkg::REQ_LIST) begin
          if (stat.out_free && stat.ptr_zero) state_next = sls_pkg::S_IDLE;
        end else if (stat.match || stat.ptr_zero) begin
          if (stat.out_free) state_next = sls_pkg::S_IDLE;
        end
      end
      default: state_next = sls_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd        = '0;
    cmd.status = sls_pkg::ST_OK;
    idle       = (state == sls_pkg::S_IDLE);
    case (state)
      sls_pkg::S_IDLE: begin
        cmd.take = req_valid;
      end
      sls_pkg::S_DECODE: begin
        case (stat.kind)
          sls_pkg::REQ_PUSH: begin
            cmd.emit   = stat.out_free;
            cmd.push   = stat.out_free && !stat.full;
            cmd.status = stat.full ? sls_pkg::ST_FULL : sls_pkg::ST_OK;
          end
          sls_pkg::REQ_POP, sls_pkg::REQ_LIST, sls_pkg::REQ_SEARCH,
          sls_pkg::REQ_UPDATE: begin
            if (stat.empty) begin
              cmd.emit   = stat.out_free;
              cmd.status = sls_pkg::ST_EMPTY;
            end else begin
              cmd.rd_top = 1'b1;
            end
          end
          default: cmd.emit = 1'b0;
        endcase
      end
      sls_pkg::S_POP: begin
        cmd.emit    = stat.out_free;
        cmd.pop     = stat.out_free;
        cmd.data_rd = 1'b1;
      end
      sls_pkg::S_WALK: begin
        if (stat.kind == sls_pkg::REQ_LIST) begin
          cmd.emit     = stat.out_free;
          cmd.data_rd  = 1'b1;
          cmd.idx_ptr  = 1'b1;
          cmd.last_ptr = 1'b1;
          cmd.rd_next  = stat.out_free && !stat.ptr_zero;
        end else if (stat.match) begin
          cmd.emit    = stat.out_free;
          cmd.idx_ptr = 1'b1;
          cmd.upd     = stat.out_free && (stat.kind == sls_pkg::REQ_UPDATE);
        end else if (stat.ptr_zero) begin
          cmd.emit   = stat.out_free;
          cmd.status = sls_pkg::ST_MISS;
        end else begin
          cmd.rd_next = 1'b1;
        end
      end
      default: cmd.emit = 1'b0;
    endcase
  end

endmodule

[hdl/sls_dp.sv]
// Datapath of the searchable LIFO stack: entry memory, fill count, walk
// pointer, request holding registers and the result register. Depends on sls_pkg.
module sls_dp #(
  parameter int DEPTH = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  sls_pkg::req_t  req,
  input  sls_pkg::cmd_t  cmd,
  output sls_pkg::stat_t stat,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output sls_pkg::rsp_t  rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int DW = sls_pkg::DATA_W;
  localparam int IW = sls_pkg::IDX_W;

  logic [DW-1:0] mem [DEPTH];

  logic [sls_pkg::KIND_W-1:0] kind;
  logic [DW-1:0]              key;
  logic [DW-1:0]              new_val;
  logic [CW-1:0]              fill;
  logic [CW-1:0]              fill_m1;
  logic [AW-1:0]              ptr;
  logic [AW-1:0]              rd_addr;
  logic [AW-1:0]              wr_addr;
  logic [DW-1:0]              wr_data;
  logic [DW-1:0]              rd_data;
  logic                       rd_en;
  logic                       wr_en;
  logic                       out_free;

  assign fill_m1  = fill - CW'(1);
  assign rd_en    = cmd.rd_top | cmd.rd_next;
  assign rd_addr  = cmd.rd_top ? fill_m1[AW-1:0] : ptr - AW'(1);
  assign wr_en    = cmd.push | cmd.upd;
  assign wr_addr  = cmd.push ? fill[AW-1:0] : ptr;
  assign wr_data  = cmd.push ? key : new_val;
  assign out_free = !rsp_valid || !rsp_stall;

  always_comb begin
    stat.kind     = kind;
    stat.full     = (fill == CW'(DEPTH));
    stat.empty    = (fill == '0);
    stat.match    = (rd_data == key);
    stat.ptr_zero = (ptr == '0);
    stat.out_free = out_free;
  end

  // entry memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      kind    <= req.req_type;
      key     <= req.value;
      new_val <= req.new_value;
    end
    if (rd_en) ptr <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.push) begin
      fill <= fill + CW'(1);
    end else if (cmd.pop) begin
      fill <= fill_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp.status <= cmd.status;
      rsp.data   <= cmd.data_rd ? rd_data : '0;
      rsp.index  <= cmd.idx_ptr ? IW'(ptr) : '0;
      rsp.last   <= cmd.last_ptr ? (ptr == '0) : 1'b1;
    end
  end

endmodule

[hdl/sls_chk.sv]
// Port-level checks for searchable_lifo_stack, bound to the top level.
// Depends on sls_pkg.
module sls_chk (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input sls_pkg::rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result beat changed");

  // one request in flight: the beat after an accept is always stalled
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while busy");

  a_error_beat: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != sls_pkg::ST_OK) |->
      rsp.last && (rsp.data == '0) && (rsp.index == '0))
    else $error("error result not a lone zero beat");

  // nothing comes out of an idle block that took no request
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid && !req_stall && !(req_valid && !req_stall) |=> !rsp_valid)
    else $error("result without request");

endmodule

bind searchable_lifo_stack sls_chk u_sls_chk (.*);
